// ===== rtl/core/fshc_pkg.sv =====
// shared types and constants for the fan speed hysteresis control core
`timescale 1ns / 1ps

package fshc_pkg;

   // field widths
   localparam int TEMP_W  = 8;
   localparam int RPM_W   = 13;
   localparam int DUTY_W  = 7;
   localparam int PWM_W   = 16;
   localparam int HOLD_W  = 24;
   localparam int PROD_W  = DUTY_W + PWM_W;
   localparam int MUL_W   = 24;

   // strategy speeds in rpm
   localparam logic [RPM_W-1:0] RPM_2300 = 13'd2300;
   localparam logic [RPM_W-1:0] RPM_2700 = 13'd2700;
   localparam logic [RPM_W-1:0] RPM_3000 = 13'd3000;
   localparam logic [RPM_W-1:0] RPM_3600 = 13'd3600;
   localparam logic [RPM_W-1:0] RPM_MAX  = 13'd4500;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2**23
   localparam logic [MUL_W-1:0] RECIP_100   = 24'd10737419;
   localparam int               RECIP_SHIFT = 30;
   localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;

   // register map, word index
   localparam logic [2:0] REG_AMB_LOW  = 3'd0;
   localparam logic [2:0] REG_AMB_HIGH = 3'd1;
   localparam logic [2:0] REG_CEILING  = 3'd2;
   localparam logic [2:0] REG_PERIOD   = 3'd3;
   localparam logic [2:0] REG_HOLD     = 3'd4;

   // input item kinds
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // result flags
   typedef struct packed {
      logic hold_active;
      logic alarm_raised;
   } rsp_flags_type;

   // duty percent of each strategy speed, piecewise-linear map floored
   //   900/30 1250/40 1900/50 2600/60 3200/70 3800/80 4200/90 4500/100
   function automatic logic [DUTY_W-1:0] duty_of_speed(input logic [RPM_W-1:0] rpm);
      logic [DUTY_W-1:0] duty;
      begin
         case (rpm)
            RPM_2300: duty = 7'd55;
            RPM_2700: duty = 7'd61;
            RPM_3000: duty = 7'd66;
            RPM_3600: duty = 7'd76;
            default:  duty = DUTY_FULL;
         endcase
         return duty;
      end
   endfunction

endpackage

// ===== rtl/core/fan_speed_hysteresis_control_core.sv =====
// top level of the fan speed hysteresis control core
`timescale 1ns / 1ps

// Fan speed control with temperature hysteresis. A sample transaction on req (tuser = 1) carries
// ambient and LED temperature; it yields one rsp transaction with target rpm, duty percent,
// the PWM compare value shared by both fans and the alarm and hold flags. A tick transaction
// (tuser = 0) counts the alarm hold counter down and yields nothing. A sample goes through band
// and hysteresis selection in the accept cycle, then two passes through one shared 24x24
// multiplier (duty times period-1, then a reciprocal multiply for the division by 100), then
// the load of the result register once that register is free. req_tready is high only
// while the sequencer is idle; the result register frees the sequencer so that the next
// transaction is taken while a result still waits on rsp. Registers are written over the
// csr APB port at byte address 4*index and are meant to change only while the core is idle.
module fan_speed_hysteresis_control_core
   import fshc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ambient_temp[7:0], led_temp[15:8]
   input  logic        req_tuser,   // kind
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // target_rpm[12:0], duty_percent[19:13],
                                    // pwm_compare[35:20], zero[39:36]
   output logic [1:0]  rsp_tuser,   // alarm_raised[0], hold_active[1]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL_DP = 2'd1;
   localparam logic [1:0] ST_MUL_RC = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0]          state_ff, state_in;

   // configuration registers
   logic [TEMP_W-1:0]   amb_low_ff, amb_low_in;
   logic [TEMP_W-1:0]   amb_high_ff, amb_high_in;
   logic [DUTY_W-1:0]   ceiling_ff, ceiling_in;
   logic [PWM_W-1:0]    period_ff, period_in;
   logic [HOLD_W-1:0]   ticks_ff, ticks_in;

   // hysteresis and hold state
   logic [3:0]          marks1_ff, marks1_in;
   logic [1:0]          marks2_ff, marks2_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;

   // per-sample working registers
   logic [RPM_W-1:0]    rpm_ff, rpm_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic [PWM_W-1:0]    per_ff, per_in;
   rsp_flags_type       flags_ff, flags_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PWM_W-1:0]    pulse_ff, pulse_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]    out_rpm_ff, out_rpm_in;
   logic [DUTY_W-1:0]   out_duty_ff, out_duty_in;
   logic [PWM_W-1:0]    out_pulse_ff, out_pulse_in;
   rsp_flags_type       out_flags_ff, out_flags_in;

   logic                req_fire;
   logic                cfg_write;
   logic [2:0]          cfg_index;
   logic                out_free;

   logic [TEMP_W-1:0]   amb;
   logic [TEMP_W-1:0]   led;
   logic                hot;
   logic [RPM_W-1:0]    band_rpm;
   logic [RPM_W-1:0]    final_rpm;
   logic [DUTY_W-1:0]   map_duty;
   logic [HOLD_W-1:0]   hold_load;

   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [2*MUL_W-1:0]  mul_p;

   assign amb       = req_tdata[7:0];
   assign led       = req_tdata[15:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // apb access
   assign csr_pready = 1'b1;
   assign cfg_index  = csr_paddr[4:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      amb_low_in  = amb_low_ff;
      amb_high_in = amb_high_ff;
      ceiling_in  = ceiling_ff;
      period_in   = period_ff;
      ticks_in    = ticks_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_AMB_LOW:  amb_low_in  = csr_pwdata[TEMP_W-1:0];
            REG_AMB_HIGH: amb_high_in = csr_pwdata[TEMP_W-1:0];
            REG_CEILING:  ceiling_in  = csr_pwdata[DUTY_W-1:0];
            REG_PERIOD:   period_in   = csr_pwdata[PWM_W-1:0];
            REG_HOLD:     ticks_in    = csr_pwdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         REG_AMB_LOW:  csr_prdata = {24'd0, amb_low_ff};
         REG_AMB_HIGH: csr_prdata = {24'd0, amb_high_ff};
         REG_CEILING:  csr_prdata = {25'd0, ceiling_ff};
         REG_PERIOD:   csr_prdata = {16'd0, period_ff};
         REG_HOLD:     csr_prdata = {8'd0, ticks_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // band selection and hysteresis marks
   always_comb begin
      marks1_in = marks1_ff;
      marks2_in = marks2_ff;
      band_rpm  = RPM_MAX;
      hot       = 1'b0;
      if (amb < amb_low_ff) begin
         if (led <= 8'd35) begin
            band_rpm = RPM_2300; marks1_in = 4'b0000;
         end else if (led <= 8'd40) begin
            band_rpm = marks1_ff[0] ? RPM_2700 : RPM_2300;
            marks1_in = {3'b000, marks1_ff[0]};
         end else if (led <= 8'd50) begin
            band_rpm = RPM_2700; marks1_in = 4'b0001;
         end else if (led <= 8'd53) begin
            band_rpm = marks1_ff[1] ? RPM_3000 : RPM_2700;
            marks1_in = {2'b00, marks1_ff[1], 1'b1};
         end else if (led <= 8'd57) begin
            band_rpm = marks1_ff[2] ? RPM_3600 : RPM_3000;
            marks1_in = {1'b0, marks1_ff[2], 2'b11};
         end else if (led <= 8'd60) begin
            band_rpm = marks1_ff[3] ? RPM_MAX : RPM_3600;
            marks1_in = {marks1_ff[3], 3'b111};
         end else begin
            band_rpm = RPM_MAX; marks1_in = 4'b1111; hot = 1'b1;
         end
      end else if (amb < amb_high_ff) begin
         if (led <= 8'd38) begin
            band_rpm = RPM_2700; marks2_in = 2'b00;
         end else if (led <= 8'd40) begin
            band_rpm = marks2_ff[0] ? RPM_3600 : RPM_2700;
            marks2_in = {1'b0, marks2_ff[0]};
         end else if (led <= 8'd53) begin
            band_rpm = RPM_3600; marks2_in = 2'b01;
         end else if (led <= 8'd57) begin
            band_rpm = marks2_ff[1] ? RPM_MAX : RPM_3600;
            marks2_in = {marks2_ff[1], 1'b1};
         end else begin
            band_rpm = RPM_MAX; marks2_in = 2'b11; hot = 1'b1;
         end
      end else begin
         hot = 1'b1;
      end
   end

   // alarm, hold load and duty selection
   always_comb begin
      flags_in.alarm_raised = hot && (hold_ff == '0);
      hold_load             = flags_in.alarm_raised ? ticks_ff : hold_ff;
      flags_in.hold_active  = (hold_load != '0);
      final_rpm             = flags_in.hold_active ? RPM_MAX : band_rpm;
      map_duty              = duty_of_speed(final_rpm);
      duty_in               = (map_duty > ceiling_ff) ? ceiling_ff : map_duty;
      per_in                = (period_ff == '0) ? '0 : period_ff - 16'd1;
      rpm_in                = final_rpm;
   end

   // shared multiplier
   always_comb begin
      if (state_ff == ST_MUL_RC) begin
         mul_a = {{(MUL_W-PROD_W){1'b0}}, prod_ff};
         mul_b = RECIP_100;
      end else begin
         mul_a = {{(MUL_W-DUTY_W){1'b0}}, duty_ff};
         mul_b = {{(MUL_W-PWM_W){1'b0}}, per_ff};
      end
      mul_p = mul_a * mul_b;
   end

   assign prod_in  = mul_p[PROD_W-1:0];
   assign pulse_in = mul_p[RECIP_SHIFT+PWM_W-1:RECIP_SHIFT];

   // sequencer, hold counter and result register
   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_rpm_in   = out_rpm_ff;
      out_duty_in  = out_duty_ff;
      out_pulse_in = out_pulse_ff;
      out_flags_in = out_flags_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_TICK) begin
                  if (hold_ff != '0) hold_in = hold_ff - 24'd1;
               end else begin
                  hold_in  = hold_load;
                  state_in = ST_MUL_DP;
               end
            end
         end
         ST_MUL_DP: state_in = ST_MUL_RC;
         ST_MUL_RC: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_rpm_in   = rpm_ff;
               out_duty_in  = duty_ff;
               out_pulse_in = pulse_ff;
               out_flags_in = flags_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   wire sample_fire = req_fire && (req_tuser == KIND_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         amb_low_ff   <= 8'd30;
         amb_high_ff  <= 8'd40;
         ceiling_ff   <= 7'd100;
         period_ff    <= 16'd1919;
         ticks_ff     <= 24'd60000;
         marks1_ff    <= '0;
         marks2_ff    <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         amb_low_ff   <= amb_low_in;
         amb_high_ff  <= amb_high_in;
         ceiling_ff   <= ceiling_in;
         period_ff    <= period_in;
         ticks_ff     <= ticks_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sample_fire) begin
            marks1_ff <= marks1_in;
            marks2_ff <= marks2_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         rpm_ff   <= rpm_in;
         duty_ff  <= duty_in;
         per_ff   <= per_in;
         flags_ff <= flags_in;
      end
      if (state_ff == ST_MUL_DP) prod_ff  <= prod_in;
      if (state_ff == ST_MUL_RC) pulse_ff <= pulse_in;
      out_rpm_ff   <= out_rpm_in;
      out_duty_ff  <= out_duty_in;
      out_pulse_ff <= out_pulse_in;
      out_flags_ff <= out_flags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, out_pulse_ff, out_duty_ff, out_rpm_ff};
   assign rsp_tuser  = {out_flags_ff.hold_active, out_flags_ff.alarm_raised};

   // an alarm or an active hold always forces full speed
   a_alarm_full_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tdata[12:0] == RPM_MAX)
      else $error("alarm or hold result without full speed");

   // duty never exceeds 100 percent, so the compare never exceeds period-1
   a_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT |-> (duty_ff <= DUTY_FULL) && (pulse_ff <= per_ff))
      else $error("duty or compare out of range");

   // the hold counter only grows by loading the hold tick count
   a_hold_load: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (hold_ff > $past(hold_ff)) |-> hold_ff == $past(ticks_ff))
      else $error("hold counter grew without a load");

   // a result register is never overwritten while it still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(out_pulse_ff))
      else $error("pending result lost");

endmodule

// ===== test/tb_fan_speed_hysteresis_control_core.sv =====
// self-checking testbench for the fan speed hysteresis control core
`timescale 1ns / 1ps

module tb_fan_speed_hysteresis_control_core;
   import fshc_pkg::*;

   // register index past the end of the map, writes to it are dropped
   localparam logic [2:0] REG_NONE = 3'd5;

   // one result transaction, unpacked
   typedef struct packed {
      logic [RPM_W-1:0]  rpm;
      logic [DUTY_W-1:0] duty;
      logic [PWM_W-1:0]  pulse;
      logic              alarm;
      logic              hold;
   } fan_result_type;

   // one line of the directed plan: either a register write or a request
   typedef struct {
      logic           is_csr;
      logic [2:0]     reg_idx;
      logic [31:0]    value;
      logic           kind;
      logic [7:0]     amb;
      logic [7:0]     led;
      logic           typed;
      fan_result_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of registers and state
   logic [7:0]        amb_low;
   logic [7:0]        amb_high;
   logic [6:0]        duty_cap;
   logic [15:0]       period;
   logic [23:0]       hold_ticks;
   logic [3:0]        band1_marks;
   logic [1:0]        band2_marks;
   logic [23:0]       hold_count;

   fan_result_type    fan_results_due[$];
   plan_row_type      plan[$];
   int unsigned       mismatch_count = 0;
   int unsigned       items_sent = 0;
   int unsigned       results_seen = 0;
   int unsigned       stall_left = 0;
   logic              quiet_mode = 1'b0;
   logic              pressure_done = 1'b0;

   fan_speed_hysteresis_control_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // knee points of the rpm to duty curve, duty at knee i is 30 + 10*i
   function automatic int unsigned curve_rpm(input int unsigned i);
      case (i)
         0: return 900;
         1: return 1250;
         2: return 1900;
         3: return 2600;
         4: return 3200;
         5: return 3800;
         6: return 4200;
         default: return 4500;
      endcase
   endfunction

   // piecewise-linear interpolation with floor
   function automatic int unsigned speed_to_duty(input int unsigned rpm);
      int unsigned i;
      int unsigned lo;
      int unsigned hi;
      if (rpm <= 900) return 30;
      if (rpm >= 4500) return 100;
      i = 0;
      while (!(rpm > curve_rpm(i) && rpm <= curve_rpm(i + 1))) i++;
      lo = curve_rpm(i);
      hi = curve_rpm(i + 1);
      return 30 + 10 * i + (10 * (rpm - lo)) / (hi - lo);
   endfunction

   // expected result of one temperature sample, updates marks and hold count
   function automatic fan_result_type predict_sample(input logic [7:0] amb,
                                                     input logic [7:0] led);
      fan_result_type r;
      logic [RPM_W-1:0] rpm;
      logic             hot;
      logic [3:0]       m1;
      logic [1:0]       m2;
      int unsigned      duty;
      int unsigned      per;
      r = '0;
      hot = 1'b0;
      if (amb < amb_low) begin
         m1 = band1_marks;
         if (led <= 35) begin
            rpm = RPM_2300; m1 = 4'b0000;
         end else if (led <= 40) begin
            rpm = m1[0] ? RPM_2700 : RPM_2300; m1 = m1 & 4'b0001;
         end else if (led <= 50) begin
            rpm = RPM_2700; m1 = 4'b0001;
         end else if (led <= 53) begin
            rpm = m1[1] ? RPM_3000 : RPM_2700; m1 = (m1 & 4'b0010) | 4'b0001;
         end else if (led <= 57) begin
            rpm = m1[2] ? RPM_3600 : RPM_3000; m1 = (m1 & 4'b0100) | 4'b0011;
         end else if (led <= 60) begin
            rpm = m1[3] ? RPM_MAX : RPM_3600; m1 = (m1 & 4'b1000) | 4'b0111;
         end else begin
            rpm = RPM_MAX; m1 = 4'b1111; hot = 1'b1;
         end
         band1_marks = m1;
      end else if (amb < amb_high) begin
         m2 = band2_marks;
         if (led <= 38) begin
            rpm = RPM_2700; m2 = 2'b00;
         end else if (led <= 40) begin
            rpm = m2[0] ? RPM_3600 : RPM_2700; m2 = m2 & 2'b01;
         end else if (led <= 53) begin
            rpm = RPM_3600; m2 = 2'b01;
         end else if (led <= 57) begin
            rpm = m2[1] ? RPM_MAX : RPM_3600; m2 = (m2 & 2'b10) | 2'b01;
         end else begin
            rpm = RPM_MAX; m2 = 2'b11; hot = 1'b1;
         end
         band2_marks = m2;
      end else begin
         rpm = RPM_MAX;
         hot = 1'b1;
      end
      // alarm only when no hold is running
      if (hot && hold_count == 0) begin
         r.alarm = 1'b1;
         hold_count = hold_ticks;
      end
      if (hold_count != 0) rpm = RPM_MAX;
      duty = speed_to_duty(rpm);
      if (duty > duty_cap) duty = duty_cap;
      per = (period == 0) ? 0 : period - 1;
      r.rpm   = rpm;
      r.duty  = DUTY_W'(duty);
      r.pulse = PWM_W'((duty * per) / 100);
      r.hold  = (hold_count != 0);
      return r;
   endfunction

   // register write as seen by the predictor
   function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_AMB_LOW:  amb_low = value[7:0];
         REG_AMB_HIGH: amb_high = value[7:0];
         REG_CEILING:  duty_cap = value[6:0];
         REG_PERIOD:   period = value[15:0];
         REG_HOLD:     hold_ticks = value[23:0];
         default:      ;
      endcase
   endfunction

   function automatic fan_result_type result_of(input int unsigned rpm,
                                                input int unsigned duty,
                                                input int unsigned pulse, input logic alarm,
                                                input logic hold);
      fan_result_type r;
      r.rpm = RPM_W'(rpm);
      r.duty = DUTY_W'(duty);
      r.pulse = PWM_W'(pulse);
      r.alarm = alarm;
      r.hold = hold;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [2:0] idx, input logic [31:0] value);
      plan_row_type p;
      p = '{default: '0};
      p.is_csr = 1'b1;
      p.reg_idx = idx;
      p.value = value;
      return p;
   endfunction

   function automatic plan_row_type item_row(input logic kind, input logic [7:0] amb,
                                             input logic [7:0] led);
      plan_row_type p;
      p = '{default: '0};
      p.kind = kind;
      p.amb = amb;
      p.led = led;
      return p;
   endfunction

   function automatic plan_row_type typed_row(input logic [7:0] amb, input logic [7:0] led,
                                              input fan_result_type want);
      plan_row_type p;
      p = item_row(KIND_SAMPLE, amb, led);
      p.typed = 1'b1;
      p.want = want;
      return p;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ambient value, half of the time around the band limits
   function automatic logic [7:0] pick_ambient();
      int signed v;
      case ($urandom_range(0, 3))
         0: v = int'(amb_low) + int'($urandom_range(0, 8)) - 4;
         1: v = int'(amb_high) + int'($urandom_range(0, 8)) - 4;
         2: v = $urandom_range(0, 80);
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // offer one request transaction and predict it once accepted
   task automatic push_item(input logic kind, input logic [7:0] amb, input logic [7:0] led,
                            input logic typed, input fan_result_type want);
      int unsigned gap;
      fan_result_type got;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {led, amb};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (kind == KIND_SAMPLE) begin
         got = predict_sample(amb, led);
         fan_results_due.push_back(typed ? want : got);
      end else if (hold_count != 0) begin
         hold_count = hold_count - 1;
      end
   endtask

   // wait until every result is back and a trailing tick has settled
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (fan_results_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // apb write: setup then access, then back to idle
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      apply_reg(idx, value);
      @(posedge clock);
   endtask

   // compare one accepted result transaction with the oldest expectation
   task automatic check_result();
      fan_result_type want;
      fan_result_type seen;
      rsp_flags_type  flags;
      flags = rsp_tuser;
      seen = result_of(rsp_tdata[12:0], rsp_tdata[19:13], rsp_tdata[35:20],
                       flags.alarm_raised, flags.hold_active);
      results_seen++;
      if (fan_results_due.size() == 0) begin
         $display("%0t: unexpected result transaction rpm=%0d duty=%0d pulse=%0d",
                  $time, seen.rpm, seen.duty, seen.pulse);
         mismatch_count++;
      end else begin
         want = fan_results_due.pop_front();
         if (seen.rpm !== want.rpm) begin
            $display("%0t: target_rpm expected %0d actual %0d", $time, want.rpm, seen.rpm);
            mismatch_count++;
         end
         if (seen.duty !== want.duty) begin
            $display("%0t: duty_percent expected %0d actual %0d", $time, want.duty, seen.duty);
            mismatch_count++;
         end
         if (seen.pulse !== want.pulse) begin
            $display("%0t: pwm_compare expected %0d actual %0d", $time, want.pulse, seen.pulse);
            mismatch_count++;
         end
         if (seen.alarm !== want.alarm) begin
            $display("%0t: alarm_raised expected %0b actual %0b", $time, want.alarm, seen.alarm);
            mismatch_count++;
         end
         if (seen.hold !== want.hold) begin
            $display("%0t: hold_active expected %0b actual %0b", $time, want.hold, seen.hold);
            mismatch_count++;
         end
      end
   endtask

   // response side: check transactions, random stalls, one long hold-off
   initial begin
      int unsigned g;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!pressure_done && results_seen >= 300) begin
            pressure_done = 1'b1;
            stall_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            g = pick_gap();
            if (g != 0) begin
               stall_left = g - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // directed plan at reset settings, then corner settings
   task automatic build_plan();
      plan.push_back(typed_row(8'd0, 8'd0, result_of(2300, 55, 1054, 1'b0, 1'b0)));
      // band one hysteresis walk
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd41));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd38));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd52));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd55));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd52));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd59));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd56));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd60));
      // band two hysteresis walk
      plan.push_back(item_row(KIND_SAMPLE, 8'd35, 8'd39));
      plan.push_back(item_row(KIND_SAMPLE, 8'd35, 8'd45));
      plan.push_back(item_row(KIND_SAMPLE, 8'd35, 8'd39));
      plan.push_back(item_row(KIND_SAMPLE, 8'd35, 8'd55));
      plan.push_back(item_row(KIND_SAMPLE, 8'd35, 8'd38));
      // tick with the counter at zero
      plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0));
      // zero hold ticks: alarm raised but no hold
      plan.push_back(csr_row(REG_HOLD, 32'd0));
      plan.push_back(typed_row(8'd255, 8'd0, result_of(4500, 100, 1918, 1'b1, 1'b0)));
      // zero period and a ceiling above full duty
      plan.push_back(csr_row(REG_PERIOD, 32'd0));
      plan.push_back(csr_row(REG_CEILING, 32'd127));
      plan.push_back(typed_row(8'd0, 8'd255, result_of(4500, 100, 0, 1'b1, 1'b0)));
      // widest period with a zero ceiling
      plan.push_back(csr_row(REG_PERIOD, 32'd65535));
      plan.push_back(csr_row(REG_CEILING, 32'd0));
      plan.push_back(typed_row(8'd0, 8'd0, result_of(2300, 0, 0, 1'b0, 1'b0)));
      // low limit above high limit
      plan.push_back(csr_row(REG_CEILING, 32'd100));
      plan.push_back(csr_row(REG_PERIOD, 32'd1919));
      plan.push_back(csr_row(REG_AMB_LOW, 32'd50));
      plan.push_back(csr_row(REG_AMB_HIGH, 32'd20));
      plan.push_back(item_row(KIND_SAMPLE, 8'd40, 8'd0));
      plan.push_back(item_row(KIND_SAMPLE, 8'd60, 8'd57));
      // write past the map, then a short hold that ticks away
      plan.push_back(csr_row(REG_NONE, 32'd3));
      plan.push_back(csr_row(REG_HOLD, 32'd5));
      plan.push_back(csr_row(REG_AMB_LOW, 32'd30));
      plan.push_back(csr_row(REG_AMB_HIGH, 32'd40));
      plan.push_back(typed_row(8'd255, 8'd255, result_of(4500, 100, 1918, 1'b1, 1'b1)));
      plan.push_back(typed_row(8'd0, 8'd0, result_of(4500, 100, 1918, 1'b0, 1'b1)));
      repeat (5) plan.push_back(item_row(KIND_TICK, 8'd255, 8'd255));
      plan.push_back(item_row(KIND_SAMPLE, 8'd0, 8'd0));
   endtask

   // random settings for one phase, extremes included
   task automatic write_random_settings();
      int unsigned r;
      r = $urandom_range(0, 9);
      write_reg(REG_AMB_LOW, (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : $urandom_range(20, 60));
      r = $urandom_range(0, 9);
      write_reg(REG_AMB_HIGH, (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : $urandom_range(25, 70));
      r = $urandom_range(0, 9);
      write_reg(REG_CEILING, (r == 0) ? 32'd0 : (r == 1) ? 32'd127 : (r == 2) ? 32'd100 :
                $urandom_range(40, 100));
      r = $urandom_range(0, 9);
      write_reg(REG_PERIOD, (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : (r == 2) ? 32'd65535 :
                $urandom_range(0, 65535));
      r = $urandom_range(0, 9);
      write_reg(REG_HOLD, (r == 0) ? 32'd0 : $urandom_range(1, 40));
   endtask

   // random request transactions
   task automatic push_random_items(input int unsigned count);
      logic       kind;
      logic [7:0] amb;
      logic [7:0] led;
      repeat (count) begin
         kind = ($urandom_range(0, 99) < 35) ? KIND_TICK : KIND_SAMPLE;
         amb = pick_ambient();
         led = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(30, 65)) :
                                             8'($urandom_range(0, 255));
         push_item(kind, amb, led, 1'b0, '0);
      end
   endtask

   // main sequence
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KIND_TICK;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      amb_low     = 8'd30;
      amb_high    = 8'd40;
      duty_cap    = 7'd100;
      period      = 16'd1919;
      hold_ticks  = 24'd60000;
      band1_marks = '0;
      band2_marks = '0;
      hold_count  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      build_plan();
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain_pipeline();
            write_reg(plan[i].reg_idx, plan[i].value);
         end else begin
            push_item(plan[i].kind, plan[i].amb, plan[i].led, plan[i].typed, plan[i].want);
         end
      end

      // random phases, each under new settings
      while (items_sent < 1950) begin
         drain_pipeline();
         write_random_settings();
         quiet_mode = ($urandom_range(0, 3) == 0);
         push_random_items($urandom_range(60, 160));
      end

      // last phase: reset limits with the longest hold
      drain_pipeline();
      quiet_mode = 1'b0;
      write_reg(REG_AMB_LOW, 32'd30);
      write_reg(REG_AMB_HIGH, 32'd40);
      write_reg(REG_CEILING, 32'd100);
      write_reg(REG_PERIOD, 32'd1919);
      write_reg(REG_HOLD, 32'd16777215);
      push_random_items(30);
      drain_pipeline();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
